@@ design/ism3d_pkg.sv @@
// ----------------------------------------------------------------------------
// ism3d_pkg - shared definitions for the 3-D Ising Metropolis engine
// Field widths, command and register codes, sequencer states and the
// control bundle passed from the sequencer to the datapath.
// ----------------------------------------------------------------------------
package ism3d_pkg;

	// lattice side length default
	localparam int SIDE_DEF = 16;

	// fixed field widths
	localparam int POS_W     = 4;
	localparam int RAND_W    = 32;
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 2;
	localparam int MAG_W     = 14;
	localparam int EN_W      = 15;
	localparam int RED_W     = 7;	// wide enough to hold any SIDE

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_FOUR   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_EIGHT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_TWELVE = 2'd2;

	// command codes; the fourth code is a no-op
	typedef enum logic [1:0] {
		CMD_LOAD    = 2'd0,
		CMD_UPDATE  = 2'd1,
		CMD_MEASURE = 2'd2
	} cmd_t;

	// sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD,
		S_UPD_RD,
		S_UPD_WAIT,
		S_UPD_DEC,
		S_MEAS,
		S_MEAS_WAIT,
		S_FIN
	} state_t;

	// sequencer to datapath controls
	typedef struct packed {
		logic clr;      // new item: clear accumulators and result
		logic load;     // load command: result spin is the loaded bit
		logic decide;   // update command: take the flip decision
		logic rd_self;  // read data this cycle is the centre site
		logic rd_nbr;   // read data this cycle is a neighbour site
		logic measure;  // read data belongs to a lattice walk
	} dp_ctl_t;

endpackage

@@ design/ism3d_spin_ram.sv @@
// ----------------------------------------------------------------------------
// ism3d_spin_ram - one-bit spin store
// One write port and one read port with registered read data. Contents
// are undefined until written.
// ----------------------------------------------------------------------------
module ism3d_spin_ram #(
	parameter int AW = 12
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic          wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic          rdata
);

	localparam int DEPTH = 1 << AW;

	logic mem [DEPTH];
	logic rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ design/ism3d_datapath.sv @@
// ----------------------------------------------------------------------------
// ism3d_datapath - spin accumulate and acceptance compare
// Separate adders accumulate neighbour matches and the lattice sums as
// read beats arrive; one 32-bit compare tests the random draw against the
// threshold picked by the match count.
// ----------------------------------------------------------------------------
module ism3d_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ism3d_pkg::dp_ctl_t            ctl,
	input  logic                          rd_bit,
	input  logic                          spin_in,
	input  logic [ism3d_pkg::RAND_W-1:0]  rand_in,
	input  logic [ism3d_pkg::CFG_W-1:0]   acc_four,
	input  logic [ism3d_pkg::CFG_W-1:0]   acc_eight,
	input  logic [ism3d_pkg::CFG_W-1:0]   acc_twelve,
	output logic                          wr_bit,
	output logic                          res_spin,
	output logic                          res_flip,
	output logic [ism3d_pkg::MAG_W-1:0]   res_mag,
	output logic [ism3d_pkg::EN_W-1:0]    res_en
);

	localparam logic [2:0] MATCH_DE4  = 3'd4;
	localparam logic [2:0] MATCH_DE8  = 3'd5;
	localparam logic [2:0] MATCH_DE12 = 3'd6;

	logic                         s_q;
	logic [2:0]                   match_q;
	logic [ism3d_pkg::MAG_W-1:0]  mag_q;
	logic [ism3d_pkg::EN_W-1:0]   en_q;
	logic                         spin_q;
	logic                         flip_q;
	logic [ism3d_pkg::CFG_W-1:0]  thr;
	logic                         flip;

	// dE = 4*matches - 12: up to three matches always flips
	always_comb begin
		case (match_q)
			MATCH_DE4:  thr = acc_four;
			MATCH_DE8:  thr = acc_eight;
			default:    thr = acc_twelve;
		endcase
		flip = (match_q < MATCH_DE4) || (rand_in < thr);
	end

	assign wr_bit = ctl.decide ? (s_q ^ flip) : spin_in;

	// centre spin and match counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= '0;
		end else if (ctl.clr) begin
			match_q <= '0;
		end else if (ctl.rd_nbr && !ctl.measure && (rd_bit == s_q)) begin
			match_q <= match_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_self) begin
			s_q <= rd_bit;
		end
	end

	// lattice sums; both wrap at their field widths
	always_ff @(posedge clk) begin
		if (ctl.clr) begin
			mag_q <= '0;
			en_q  <= '0;
		end else if (ctl.measure) begin
			if (ctl.rd_self) begin
				mag_q <= mag_q + (rd_bit ? ism3d_pkg::MAG_W'(1) : '1);
			end
			if (ctl.rd_nbr) begin
				en_q <= en_q + ((rd_bit == s_q) ? '1 : ism3d_pkg::EN_W'(1));
			end
		end
	end

	// per-site result bits
	always_ff @(posedge clk) begin
		if (ctl.clr) begin
			spin_q <= 1'b0;
			flip_q <= 1'b0;
		end else if (ctl.load) begin
			spin_q <= spin_in;
		end else if (ctl.decide) begin
			spin_q <= s_q ^ flip;
			flip_q <= flip;
		end
	end

	assign res_spin = spin_q;
	assign res_flip = flip_q;
	assign res_mag  = mag_q;
	assign res_en   = en_q;

	// six neighbours at most can match
	a_match_range: assert property (@(posedge clk) disable iff (!arst_n)
		match_q <= MATCH_DE12)
		else $error("neighbour match count out of range");

endmodule

@@ design/ism3d_ctrl.sv @@
// ----------------------------------------------------------------------------
// ism3d_ctrl - command sequencer and address generator
// Steps through the reads of one update (centre then six neighbours) or
// the walk of a measure (each site and its three forward neighbours),
// issuing one spin RAM read a cycle and tagging the returning beats.
// ----------------------------------------------------------------------------
module ism3d_ctrl #(
	parameter int SIDE = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  ism3d_pkg::cmd_t           cmd,
	input  logic [$clog2(SIDE)-1:0]   px,
	input  logic [$clog2(SIDE)-1:0]   py,
	input  logic [$clog2(SIDE)-1:0]   pz,
	input  logic                      out_free,
	output logic                      busy,
	output logic                      fin,
	output ism3d_pkg::dp_ctl_t        ctl,
	output logic                      mem_we,
	output logic [3*$clog2(SIDE)-1:0] mem_waddr,
	output logic                      mem_re,
	output logic [3*$clog2(SIDE)-1:0] mem_raddr
);

	localparam int CW = $clog2(SIDE);
	localparam logic [CW-1:0] LAST = CW'(SIDE - 1);
	localparam logic [2:0] UPD_LAST = 3'd6;
	localparam logic [1:0] SUB_LAST = 2'd3;

	ism3d_pkg::state_t state_q, state_d;

	logic [2:0]    k_q;
	logic [1:0]    sub_q;
	logic [CW-1:0] wx_q, wy_q, wz_q;
	logic          self_s1, nbr_s1;
	logic          site_end, walk_end;

	function automatic logic [CW-1:0] inc_c(input logic [CW-1:0] c);
		return (c == LAST) ? '0 : c + 1'b1;
	endfunction

	function automatic logic [CW-1:0] dec_c(input logic [CW-1:0] c);
		return (c == '0) ? LAST : c - 1'b1;
	endfunction

	assign site_end = (sub_q == SUB_LAST);
	assign walk_end = site_end && (wx_q == LAST) && (wy_q == LAST) && (wz_q == LAST);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ism3d_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and strobes
	always_comb begin
		state_d = state_q;
		busy    = 1'b1;
		fin     = 1'b0;
		mem_we  = 1'b0;
		mem_re  = 1'b0;
		unique case (state_q)
			ism3d_pkg::S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					unique case (cmd)
						ism3d_pkg::CMD_LOAD:    state_d = ism3d_pkg::S_LOAD;
						ism3d_pkg::CMD_UPDATE:  state_d = ism3d_pkg::S_UPD_RD;
						ism3d_pkg::CMD_MEASURE: state_d = ism3d_pkg::S_MEAS;
						default:                state_d = ism3d_pkg::S_FIN;
					endcase
				end
			end
			ism3d_pkg::S_LOAD: begin
				mem_we  = 1'b1;
				state_d = ism3d_pkg::S_FIN;
			end
			ism3d_pkg::S_UPD_RD: begin
				mem_re = 1'b1;
				if (k_q == UPD_LAST) begin
					state_d = ism3d_pkg::S_UPD_WAIT;
				end
			end
			ism3d_pkg::S_UPD_WAIT: begin
				state_d = ism3d_pkg::S_UPD_DEC;
			end
			ism3d_pkg::S_UPD_DEC: begin
				mem_we  = 1'b1;
				state_d = ism3d_pkg::S_FIN;
			end
			ism3d_pkg::S_MEAS: begin
				mem_re = 1'b1;
				if (walk_end) begin
					state_d = ism3d_pkg::S_MEAS_WAIT;
				end
			end
			ism3d_pkg::S_MEAS_WAIT: begin
				state_d = ism3d_pkg::S_FIN;
			end
			ism3d_pkg::S_FIN: begin
				if (out_free) begin
					fin     = 1'b1;
					state_d = ism3d_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ism3d_pkg::S_IDLE;
			end
		endcase
	end

	// update read counter and lattice walk counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q   <= '0;
			sub_q <= '0;
			wx_q  <= '0;
			wy_q  <= '0;
			wz_q  <= '0;
		end else if (start) begin
			k_q   <= '0;
			sub_q <= '0;
			wx_q  <= '0;
			wy_q  <= '0;
			wz_q  <= '0;
		end else if (state_q == ism3d_pkg::S_UPD_RD) begin
			k_q <= k_q + 3'd1;
		end else if (state_q == ism3d_pkg::S_MEAS) begin
			sub_q <= sub_q + 2'd1;
			if (site_end) begin
				wz_q <= inc_c(wz_q);
				if (wz_q == LAST) begin
					wy_q <= inc_c(wy_q);
					if (wy_q == LAST) begin
						wx_q <= inc_c(wx_q);
					end
				end
			end
		end
	end

	// read address: centre first, then neighbours
	always_comb begin
		mem_raddr = {wx_q, wy_q, wz_q};
		if (state_q == ism3d_pkg::S_UPD_RD) begin
			case (k_q)
				3'd1:    mem_raddr = {inc_c(px), py, pz};
				3'd2:    mem_raddr = {dec_c(px), py, pz};
				3'd3:    mem_raddr = {px, inc_c(py), pz};
				3'd4:    mem_raddr = {px, dec_c(py), pz};
				3'd5:    mem_raddr = {px, py, inc_c(pz)};
				3'd6:    mem_raddr = {px, py, dec_c(pz)};
				default: mem_raddr = {px, py, pz};
			endcase
		end else begin
			case (sub_q)
				2'd1:    mem_raddr = {inc_c(wx_q), wy_q, wz_q};
				2'd2:    mem_raddr = {wx_q, inc_c(wy_q), wz_q};
				2'd3:    mem_raddr = {wx_q, wy_q, inc_c(wz_q)};
				default: mem_raddr = {wx_q, wy_q, wz_q};
			endcase
		end
	end

	assign mem_waddr = {px, py, pz};

	// tag each read beat for the cycle its data returns
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			self_s1 <= 1'b0;
			nbr_s1  <= 1'b0;
		end else begin
			self_s1 <= ((state_q == ism3d_pkg::S_UPD_RD) && (k_q == '0))
				|| ((state_q == ism3d_pkg::S_MEAS) && (sub_q == '0));
			nbr_s1  <= ((state_q == ism3d_pkg::S_UPD_RD) && (k_q != '0))
				|| ((state_q == ism3d_pkg::S_MEAS) && (sub_q != '0));
		end
	end

	assign ctl.clr     = start;
	assign ctl.load    = (state_q == ism3d_pkg::S_LOAD);
	assign ctl.decide  = (state_q == ism3d_pkg::S_UPD_DEC);
	assign ctl.rd_self = self_s1;
	assign ctl.rd_nbr  = nbr_s1;
	assign ctl.measure = (state_q == ism3d_pkg::S_MEAS) || (state_q == ism3d_pkg::S_MEAS_WAIT);

	// the centre read returns the cycle after it is issued
	a_self_tag: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ism3d_pkg::S_UPD_RD && k_q == '0) |=> ctl.rd_self)
		else $error("centre read beat not tagged");

	// a walk ends only on the last site's last beat
	a_walk_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ism3d_pkg::S_MEAS && state_d != ism3d_pkg::S_MEAS)
		|-> (sub_q == SUB_LAST && wx_q == LAST && wy_q == LAST && wz_q == LAST))
		else $error("lattice walk left early");

	// decision follows the last neighbour beat
	a_dec_after_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ism3d_pkg::S_UPD_DEC) |-> ($past(state_q) == ism3d_pkg::S_UPD_WAIT
		&& $past(ctl.rd_nbr)))
		else $error("update decided before all neighbours were read");

	// no memory write while a read beat is in flight
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> !(ctl.rd_self || ctl.rd_nbr))
		else $error("spin write during a read sequence");

endmodule

@@ design/ising3d_metropolis_update.sv @@
// One item at a time: the next input beat is taken at the edge at which the result
// beat can first leave. The spin RAM gives one read a cycle, seven per update and
// four per site on a measure. Output stalls hold the result in the final state.
// Reset clears control and thresholds; the spin store needs each site loaded.
// ----------------------------------------------------------------------------
// ising3d_metropolis_update - 3-D Ising lattice Metropolis engine
// Periodic cubic lattice of one-bit spins with load, Metropolis update and
// whole-lattice measure commands; acceptance thresholds set by software.
// ----------------------------------------------------------------------------
module ising3d_metropolis_update #(
	parameter int SIDE = ism3d_pkg::SIDE_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              cfg_we,
	input  logic [ism3d_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [ism3d_pkg::CFG_W-1:0]       cfg_data,
	// input channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        cmd,
	input  logic [ism3d_pkg::POS_W-1:0]       pos_x,
	input  logic [ism3d_pkg::POS_W-1:0]       pos_y,
	input  logic [ism3d_pkg::POS_W-1:0]       pos_z,
	input  logic                              spin_value,
	input  logic [ism3d_pkg::RAND_W-1:0]      rand_frac,
	// output channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              spin_now,
	output logic                              flipped,
	output logic signed [ism3d_pkg::MAG_W-1:0] mag_sum,
	output logic signed [ism3d_pkg::EN_W-1:0]  energy_sum
);

	localparam int CW = $clog2(SIDE);
	localparam int AW = 3 * CW;
	localparam logic [ism3d_pkg::RED_W-1:0] SIDE_R = ism3d_pkg::RED_W'(SIDE);

	logic [ism3d_pkg::CFG_W-1:0]  acc_four_q, acc_eight_q, acc_twelve_q;
	logic [CW-1:0]                x_q, y_q, z_q;
	logic                         sv_q;
	logic [ism3d_pkg::RAND_W-1:0] rand_q;
	logic                         busy, fin, start;
	ism3d_pkg::dp_ctl_t           ctl;
	logic                         mem_we, mem_re, rd_bit, wr_bit;
	logic [AW-1:0]                mem_waddr, mem_raddr;
	logic                         res_spin, res_flip;
	logic [ism3d_pkg::MAG_W-1:0]  res_mag;
	logic [ism3d_pkg::EN_W-1:0]   res_en;
	logic                         out_valid_q, spin_q, flip_q;
	logic [ism3d_pkg::MAG_W-1:0]  mag_q;
	logic [ism3d_pkg::EN_W-1:0]   en_q;

	// coordinate modulo SIDE by repeated subtraction (input is below 16)
	function automatic logic [ism3d_pkg::RED_W-1:0] wrap_pos(
		input logic [ism3d_pkg::POS_W-1:0] p);
		logic [ism3d_pkg::RED_W-1:0] v;
		v = ism3d_pkg::RED_W'(p);
		for (int i = 0; i < 7; i++) begin
			if (v >= SIDE_R) begin
				v = v - SIDE_R;
			end
		end
		return v;
	endfunction

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_four_q   <= '0;
			acc_eight_q  <= '0;
			acc_twelve_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				ism3d_pkg::REG_ACCEPT_FOUR:   acc_four_q   <= cfg_data;
				ism3d_pkg::REG_ACCEPT_EIGHT:  acc_eight_q  <= cfg_data;
				ism3d_pkg::REG_ACCEPT_TWELVE: acc_twelve_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input beat capture
	assign in_stall = busy;
	assign start    = in_valid && !busy;

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= CW'(wrap_pos(pos_x));
			y_q    <= CW'(wrap_pos(pos_y));
			z_q    <= CW'(wrap_pos(pos_z));
			sv_q   <= spin_value;
			rand_q <= rand_frac;
		end
	end

	ism3d_ctrl #(
		.SIDE (SIDE)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cmd       (ism3d_pkg::cmd_t'(cmd)),
		.px        (x_q),
		.py        (y_q),
		.pz        (z_q),
		.out_free  (!out_valid_q || !out_stall),
		.busy      (busy),
		.fin       (fin),
		.ctl       (ctl),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr)
	);

	ism3d_spin_ram #(
		.AW (AW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (wr_bit),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (rd_bit)
	);

	ism3d_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.rd_bit     (rd_bit),
		.spin_in    (sv_q),
		.rand_in    (rand_q),
		.acc_four   (acc_four_q),
		.acc_eight  (acc_eight_q),
		.acc_twelve (acc_twelve_q),
		.wr_bit     (wr_bit),
		.res_spin   (res_spin),
		.res_flip   (res_flip),
		.res_mag    (res_mag),
		.res_en     (res_en)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			spin_q <= res_spin;
			flip_q <= res_flip;
			mag_q  <= res_mag;
			en_q   <= res_en;
		end
	end

	assign out_valid  = out_valid_q;
	assign spin_now   = spin_q;
	assign flipped    = flip_q;
	assign mag_sum    = $signed(mag_q);
	assign energy_sum = $signed(en_q);

	// a result beat is loaded only when the output register is free
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		fin |-> (!out_valid_q || !out_stall))
		else $error("result beat overwritten");

	// the block takes no input beat while working on an item
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> in_stall)
		else $error("input accepted while busy");

	// one result beat per item
	a_fin_once: assert property (@(posedge clk) disable iff (!arst_n)
		fin |=> !fin)
		else $error("two results for one item");

endmodule

@@ test/ism3d_metropolis_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ism3d_metropolis_checker - result checker for the 3-D Ising Metropolis engine
// Watches the configuration port and both channels. It keeps its own copy of
// the lattice and thresholds, predicts the outcome of every accepted input
// beat and compares each result beat with the oldest outcome awaited.
// ----------------------------------------------------------------------------
module ism3d_metropolis_checker #(
	parameter int SIDE = ism3d_pkg::SIDE_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [ism3d_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [ism3d_pkg::CFG_W-1:0]        cfg_data,
	input  logic                               in_valid,
	input  logic                               in_stall,
	input  logic [1:0]                         cmd,
	input  logic [ism3d_pkg::POS_W-1:0]        pos_x,
	input  logic [ism3d_pkg::POS_W-1:0]        pos_y,
	input  logic [ism3d_pkg::POS_W-1:0]        pos_z,
	input  logic                               spin_value,
	input  logic [ism3d_pkg::RAND_W-1:0]       rand_frac,
	input  logic                               out_valid,
	input  logic                               out_stall,
	input  logic                               spin_now,
	input  logic                               flipped,
	input  logic signed [ism3d_pkg::MAG_W-1:0] mag_sum,
	input  logic signed [ism3d_pkg::EN_W-1:0]  energy_sum,
	output int                                 fail_count,
	output int                                 pending
);

	localparam int SITES = SIDE * SIDE * SIDE;

	typedef struct packed {
		logic                               spin;
		logic                               flip;
		logic signed [ism3d_pkg::MAG_W-1:0] mag;
		logic signed [ism3d_pkg::EN_W-1:0]  energy;
	} outcome_t;

	// shadow lattice and acceptance thresholds
	bit                          spins [SITES];
	logic [ism3d_pkg::CFG_W-1:0] thr_four, thr_eight, thr_twelve;
	outcome_t                    pending_outcomes [$];

	// periodic wraparound on every axis
	function automatic int site(int x, int y, int z);
		return ((x % SIDE) * SIDE + (y % SIDE)) * SIDE + (z % SIDE);
	endfunction

	function automatic int spin_of(int x, int y, int z);
		return spins[site(x, y, z)] ? 1 : -1;
	endfunction

	// outcome of one input beat; loads and flips land in the shadow lattice
	function automatic outcome_t metropolis_outcome(logic [1:0] op, int x, int y, int z,
			logic sv, logic [ism3d_pkg::RAND_W-1:0] frac);
		outcome_t o;
		int       s, nsum, de, mag, en;
		logic     take;
		o = '0;
		case (op)
		ism3d_pkg::CMD_LOAD: begin
			spins[site(x, y, z)] = sv;
			o.spin = sv;
		end
		ism3d_pkg::CMD_UPDATE: begin
			s    = spin_of(x, y, z);
			nsum = spin_of(x + 1, y, z) + spin_of(x + SIDE - 1, y, z)
			     + spin_of(x, y + 1, z) + spin_of(x, y + SIDE - 1, z)
			     + spin_of(x, y, z + 1) + spin_of(x, y, z + SIDE - 1);
			de   = 2 * s * nsum;
			if (de <= 0)
				take = 1'b1;
			else if (de == 4)
				take = frac < thr_four;
			else if (de == 8)
				take = frac < thr_eight;
			else
				take = frac < thr_twelve;
			if (take)
				spins[site(x, y, z)] = ~spins[site(x, y, z)];
			o.spin = spins[site(x, y, z)];
			o.flip = take;
		end
		ism3d_pkg::CMD_MEASURE: begin
			// magnetisation and forward-bond energy over the whole cube
			mag = 0;
			en  = 0;
			for (int i = 0; i < SIDE; i++)
				for (int j = 0; j < SIDE; j++)
					for (int k = 0; k < SIDE; k++) begin
						s   = spin_of(i, j, k);
						mag += s;
						en  -= s * (spin_of(i + 1, j, k) + spin_of(i, j + 1, k)
						          + spin_of(i, j, k + 1));
					end
			o.mag    = ism3d_pkg::MAG_W'(mag);
			o.energy = ism3d_pkg::EN_W'(en);
		end
		default: ;	// spare code: nothing changes, all fields zero
		endcase
		return o;
	endfunction

	task automatic report_mismatch(string field, int want_v, int got_v);
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
		fail_count++;
	endtask

	// register writes, result beats, then input beats of this edge
	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		if (!arst_n) begin
			thr_four   = '0;
			thr_eight  = '0;
			thr_twelve = '0;
			pending_outcomes.delete();
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
				ism3d_pkg::REG_ACCEPT_FOUR:   thr_four   = cfg_data;
				ism3d_pkg::REG_ACCEPT_EIGHT:  thr_eight  = cfg_data;
				ism3d_pkg::REG_ACCEPT_TWELVE: thr_twelve = cfg_data;
				default: ;	// unmapped index is ignored
				endcase
			end

			if (out_valid && !out_stall) begin
				if (pending_outcomes.size() == 0) begin
					$display("%0t: result beat with no outcome awaited", $time);
					fail_count++;
				end else begin
					want = pending_outcomes.pop_front();
					if (spin_now !== want.spin)
						report_mismatch("spin_now", int'(want.spin), int'(spin_now));
					if (flipped !== want.flip)
						report_mismatch("flipped", int'(want.flip), int'(flipped));
					if (mag_sum !== want.mag)
						report_mismatch("mag_sum", int'(want.mag), int'(mag_sum));
					if (energy_sum !== want.energy)
						report_mismatch("energy_sum", int'(want.energy),
							int'(energy_sum));
				end
			end

			if (in_valid && !in_stall)
				pending_outcomes.push_back(metropolis_outcome(cmd, int'(pos_x),
					int'(pos_y), int'(pos_z), spin_value, rand_frac));

			pending <= pending_outcomes.size();
		end
	end

endmodule

@@ test/ising3d_metropolis_update_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ising3d_metropolis_update_test - testbench for the 3-D Ising Metropolis engine
// Fills the lattice once, runs a short directed set over every energy step and
// command, then random beats under three idling regimes. A separate checker
// predicts and compares.
// ----------------------------------------------------------------------------
module ising3d_metropolis_update_test;

	localparam int SIDE          = ism3d_pkg::SIDE_DEF;
	localparam int PHASE_ITEMS   = 400;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 32;
	localparam int CYCLE_LIMIT   = 3_000_000;

	localparam logic [1:0]                      CMD_SPARE = 2'd3;
	localparam logic [ism3d_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam logic [ism3d_pkg::RAND_W-1:0]    FRAC_MAX  = '1;
	localparam logic [ism3d_pkg::POS_W-1:0]     P_ZERO    = '0;
	localparam logic [ism3d_pkg::POS_W-1:0]     P_LAST    = ism3d_pkg::POS_W'(SIDE - 1);

	logic                               clk        = 1'b0;
	logic                               arst_n     = 1'b0;
	logic                               cfg_we     = 1'b0;
	logic [ism3d_pkg::CFG_IDX_W-1:0]    cfg_idx    = '0;
	logic [ism3d_pkg::CFG_W-1:0]        cfg_data   = '0;
	logic                               in_valid   = 1'b0;
	logic                               in_stall;
	logic [1:0]                         cmd        = ism3d_pkg::CMD_LOAD;
	logic [ism3d_pkg::POS_W-1:0]        pos_x      = '0;
	logic [ism3d_pkg::POS_W-1:0]        pos_y      = '0;
	logic [ism3d_pkg::POS_W-1:0]        pos_z      = '0;
	logic                               spin_value = 1'b0;
	logic [ism3d_pkg::RAND_W-1:0]       rand_frac  = '0;
	logic                               out_valid;
	logic                               out_stall  = 1'b0;
	logic                               spin_now;
	logic                               flipped;
	logic signed [ism3d_pkg::MAG_W-1:0] mag_sum;
	logic signed [ism3d_pkg::EN_W-1:0]  energy_sum;

	int fail_count;
	int pending;

	// idling percentages and output hold-off requests
	int tx_idle_pct = 19;
	int rx_idle_pct = 63;
	int hold_reqs   = 0;
	int hold_seen   = 0;
	int hold_left   = 0;

	longint                      cycle_count = 0;
	logic [ism3d_pkg::CFG_W-1:0] thr [3];
	int n_load = 0, n_update = 0, n_measure = 0, n_spare = 0, n_settings = 0;

	ising3d_metropolis_update #(.SIDE(SIDE)) u_dut (.*);

	ism3d_metropolis_checker #(.SIDE(SIDE)) u_checker (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// result side: random stalls, or a long hold-off when one is requested
	always @(posedge clk) begin
		if (hold_reqs != hold_seen) begin
			hold_seen <= hold_reqs;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: run stopped after %0d cycles", $time, cycle_count);
			$display("Mismatches found");
			$finish;
		end
	end

	// coordinate with periodic wraparound
	function automatic logic [ism3d_pkg::POS_W-1:0] pos_of(int c);
		return ism3d_pkg::POS_W'(c % SIDE);
	endfunction

	function automatic logic [ism3d_pkg::POS_W-1:0] rand_pos();
		return ism3d_pkg::POS_W'($urandom_range(0, SIDE - 1));
	endfunction

	function automatic logic rand_bit();
		return 1'($urandom_range(0, 1));
	endfunction

	// offer one beat after a random gap and hold it until accepted
	task automatic send_beat(logic [1:0] op, logic [ism3d_pkg::POS_W-1:0] x,
			logic [ism3d_pkg::POS_W-1:0] y, logic [ism3d_pkg::POS_W-1:0] z, logic sv,
			logic [ism3d_pkg::RAND_W-1:0] frac);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		cmd        <= op;
		pos_x      <= x;
		pos_y      <= y;
		pos_z      <= z;
		spin_value <= sv;
		rand_frac  <= frac;
		do @(posedge clk); while (in_stall);
		case (op)
		ism3d_pkg::CMD_LOAD:    n_load++;
		ism3d_pkg::CMD_UPDATE:  n_update++;
		ism3d_pkg::CMD_MEASURE: n_measure++;
		default:                n_spare++;
		endcase
	endtask

	// sender pauses until every awaited result has arrived
	task automatic wait_for_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// only called with the block idle; the unmapped index is poked too
	task automatic set_thresholds(logic [ism3d_pkg::CFG_W-1:0] four,
			logic [ism3d_pkg::CFG_W-1:0] eight, logic [ism3d_pkg::CFG_W-1:0] twelve);
		thr[0]   = four;
		thr[1]   = eight;
		thr[2]   = twelve;
		cfg_we   <= 1'b1;
		cfg_idx  <= REG_SPARE;
		cfg_data <= ~four;
		@(posedge clk);
		cfg_idx  <= ism3d_pkg::REG_ACCEPT_FOUR;
		cfg_data <= four;
		@(posedge clk);
		cfg_idx  <= ism3d_pkg::REG_ACCEPT_EIGHT;
		cfg_data <= eight;
		@(posedge clk);
		cfg_idx  <= ism3d_pkg::REG_ACCEPT_TWELVE;
		cfg_data <= twelve;
		@(posedge clk);
		cfg_we   <= 1'b0;
		n_settings++;
	endtask

	// load every site once, so no later read touches an unwritten one
	task automatic fill_lattice(logic sv);
		for (int x = 0; x < SIDE; x++)
			for (int y = 0; y < SIDE; y++)
				for (int z = 0; z < SIDE; z++)
					send_beat(ism3d_pkg::CMD_LOAD, pos_of(x), pos_of(y), pos_of(z), sv,
						$urandom);
	endtask

	// set one site and its six neighbours
	task automatic load_star(int x, int y, int z, logic centre, logic nbr);
		send_beat(ism3d_pkg::CMD_LOAD, pos_of(x), pos_of(y), pos_of(z), centre, $urandom);
		send_beat(ism3d_pkg::CMD_LOAD, pos_of(x + 1), pos_of(y), pos_of(z), nbr, $urandom);
		send_beat(ism3d_pkg::CMD_LOAD, pos_of(x + SIDE - 1), pos_of(y), pos_of(z), nbr,
			$urandom);
		send_beat(ism3d_pkg::CMD_LOAD, pos_of(x), pos_of(y + 1), pos_of(z), nbr, $urandom);
		send_beat(ism3d_pkg::CMD_LOAD, pos_of(x), pos_of(y + SIDE - 1), pos_of(z), nbr,
			$urandom);
		send_beat(ism3d_pkg::CMD_LOAD, pos_of(x), pos_of(y), pos_of(z + 1), nbr, $urandom);
		send_beat(ism3d_pkg::CMD_LOAD, pos_of(x), pos_of(y), pos_of(z + SIDE - 1), nbr,
			$urandom);
	endtask

	// random fractions, biased towards the extremes and the threshold boundaries
	function automatic logic [ism3d_pkg::RAND_W-1:0] pick_frac();
		logic [ism3d_pkg::CFG_W-1:0] near;
		case ($urandom_range(0, 7))
		0: return '0;
		1: return FRAC_MAX;
		2, 3: begin
			near = thr[$urandom_range(0, 2)];
			return near + $urandom_range(0, 2) - 1;
		end
		default: return $urandom;
		endcase
	endfunction

	// mostly updates and loads, rare lattice walks, a little spare-code noise
	task automatic send_random_item();
		int pick;
		pick = $urandom_range(0, 999);
		if (pick < 4)
			send_beat(ism3d_pkg::CMD_MEASURE, rand_pos(), rand_pos(), rand_pos(),
				rand_bit(), $urandom);
		else if (pick < 24)
			send_beat(CMD_SPARE, rand_pos(), rand_pos(), rand_pos(), rand_bit(), $urandom);
		else if (pick < 324)
			send_beat(ism3d_pkg::CMD_LOAD, rand_pos(), rand_pos(), rand_pos(),
				rand_bit(), $urandom);
		else
			send_beat(ism3d_pkg::CMD_UPDATE, rand_pos(), rand_pos(), rand_pos(),
				rand_bit(), pick_frac());
	endtask

	task automatic run_phase(int tx_pct, int rx_pct, int count);
		tx_idle_pct = tx_pct;
		rx_idle_pct <= rx_pct;
		for (int i = 0; i < count; i++)
			send_random_item();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// all spins up: full magnetisation, then walk the origin through each energy step
		set_thresholds('0, 32'h8000_0000, FRAC_MAX);
		fill_lattice(1'b1);
		send_beat(ism3d_pkg::CMD_MEASURE, P_ZERO, P_ZERO, P_ZERO, 1'b0, '0);
		send_beat(ism3d_pkg::CMD_UPDATE, P_ZERO, P_ZERO, P_ZERO, 1'b0, FRAC_MAX - 1);
		send_beat(ism3d_pkg::CMD_UPDATE, P_ZERO, P_ZERO, P_ZERO, 1'b1, FRAC_MAX);
		send_beat(ism3d_pkg::CMD_UPDATE, P_ZERO, P_ZERO, P_ZERO, 1'b0, FRAC_MAX);
		send_beat(ism3d_pkg::CMD_LOAD, P_LAST, P_ZERO, P_ZERO, 1'b0, '0);
		send_beat(ism3d_pkg::CMD_UPDATE, P_ZERO, P_ZERO, P_ZERO, 1'b0, 32'h7FFF_FFFF);
		send_beat(ism3d_pkg::CMD_UPDATE, P_ZERO, P_ZERO, P_ZERO, 1'b1, FRAC_MAX);
		send_beat(ism3d_pkg::CMD_UPDATE, P_ZERO, P_ZERO, P_ZERO, 1'b0, 32'h8000_0000);
		send_beat(ism3d_pkg::CMD_LOAD, P_ZERO, P_LAST, P_ZERO, 1'b0, FRAC_MAX);
		send_beat(ism3d_pkg::CMD_UPDATE, P_ZERO, P_ZERO, P_ZERO, 1'b1, '0);
		send_beat(ism3d_pkg::CMD_LOAD, P_ZERO, P_ZERO, P_LAST, 1'b0, '0);
		send_beat(ism3d_pkg::CMD_UPDATE, P_ZERO, P_ZERO, P_ZERO, 1'b0, '0);
		send_beat(ism3d_pkg::CMD_UPDATE, P_ZERO, P_ZERO, P_ZERO, 1'b0, '0);
		send_beat(ism3d_pkg::CMD_UPDATE, P_LAST, P_LAST, P_LAST, 1'b1, FRAC_MAX);
		send_beat(CMD_SPARE, P_LAST, P_LAST, P_LAST, 1'b1, FRAC_MAX);
		send_beat(CMD_SPARE, P_ZERO, P_ZERO, P_ZERO, 1'b0, '0);
		send_beat(ism3d_pkg::CMD_MEASURE, P_LAST, P_LAST, P_LAST, 1'b1, FRAC_MAX);

		// centre against six opposite neighbours: steepest drop, then steepest rise
		wait_for_results();
		set_thresholds(FRAC_MAX, FRAC_MAX, FRAC_MAX);
		load_star(7, 8, 9, 1'b1, 1'b0);
		send_beat(ism3d_pkg::CMD_UPDATE, pos_of(7), pos_of(8), pos_of(9), 1'b0, FRAC_MAX);
		send_beat(ism3d_pkg::CMD_UPDATE, pos_of(7), pos_of(8), pos_of(9), 1'b1, FRAC_MAX);
		send_beat(ism3d_pkg::CMD_MEASURE, P_ZERO, P_ZERO, P_ZERO, 1'b0, '0);

		// all-down star across the far corner with zero thresholds: no uphill step
		wait_for_results();
		set_thresholds('0, '0, '0);
		load_star(SIDE - 1, 0, SIDE - 1, 1'b0, 1'b0);
		send_beat(ism3d_pkg::CMD_UPDATE, P_LAST, P_ZERO, P_LAST, 1'b0, '0);

		// random beats, sender idles lightly and receiver heavily
		wait_for_results();
		set_thresholds($urandom, $urandom, $urandom);
		run_phase(19, 63, PHASE_ITEMS / 2);
		wait_for_results();
		run_phase(19, 63, PHASE_ITEMS / 2);

		// temperature-like thresholds, idling the other way round
		wait_for_results();
		set_thresholds(32'h4000_0000, 32'h1000_0000, 32'h0400_0000);
		run_phase(63, 19, PHASE_ITEMS);

		// no idling, opened by a long output hold-off so the input backs up
		wait_for_results();
		set_thresholds($urandom, $urandom, $urandom);
		hold_reqs <= hold_reqs + 1;
		run_phase(0, 0, PHASE_ITEMS);

		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Covered %0d loads (one full fill), %0d updates, %0d measures, %0d spare",
			n_load, n_update, n_measure, n_spare);
		$display("beats over %0d threshold settings, three idling regimes and one hold-off",
			n_settings);
		if (fail_count == 0 && pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
